/* rtl/dbtt_pkg.sv */
// dbtt_pkg: shared types, codes and timing helpers for the DRAM bank timing tracker.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package dbtt_pkg;

  localparam int TIME_BITS     = 48;
  localparam int ROW_BITS      = 16;
  localparam int LA_BITS       = 16;
  localparam int OFF_BITS      = 34;
  localparam int SUM_BITS      = 12;
  localparam int BUSY_BITS     = 33;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 56;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic [1:0] ACTN_QUERY = 2'd0;
  localparam logic [1:0] ACTN_ISSUE = 2'd1;
  localparam logic [1:0] ACTN_TICK  = 2'd2;

  localparam logic [2:0] CMD_ACT = 3'd0;
  localparam logic [2:0] CMD_RD  = 3'd1;
  localparam logic [2:0] CMD_WR  = 3'd2;
  localparam logic [2:0] CMD_PRE = 3'd3;
  localparam logic [2:0] CMD_PDA = 3'd4;
  localparam logic [2:0] CMD_PDF = 3'd5;
  localparam logic [2:0] CMD_PDS = 3'd6;
  localparam logic [2:0] CMD_PU  = 3'd7;

  localparam logic [2:0] MODE_CLOSED = 3'd0;
  localparam logic [2:0] MODE_OPEN   = 3'd1;
  localparam logic [2:0] MODE_PDA    = 3'd2;
  localparam logic [2:0] MODE_PDF    = 3'd3;
  localparam logic [2:0] MODE_PDS    = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ACT_TIMING  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COL_TIMING  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PD_TIMING   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REF_OP_TIME = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REF_SPACING = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REF_ROWS    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REF_ENABLE  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_PD    = 3'd7;

  localparam logic [31:0] REF_SPACING_RST = 32'd7800;
  localparam logic [16:0] REF_ROWS_RST    = 17'd1024;

  typedef struct packed {
    logic [39:0]          act_timing;
    logic [55:0]          col_timing;
    logic [23:0]          pd_timing;
    logic [15:0]          ref_op_time;
    logic [31:0]          ref_spacing;
    logic [16:0]          ref_rows;
    logic                 ref_en;
    logic [BUSY_BITS-1:0] ref_busy;
  } cfg_t;

  typedef struct packed {
    logic [2:0]           mode;
    logic [ROW_BITS-1:0]  open_row;
    logic [TIME_BITS-1:0] e_act;
    logic [TIME_BITS-1:0] e_pre;
    logic [TIME_BITS-1:0] e_rd;
    logic [TIME_BITS-1:0] e_wr;
    logic [TIME_BITS-1:0] e_pd;
    logic [TIME_BITS-1:0] e_pu;
    logic [TIME_BITS-1:0] e_ref;
    logic [TIME_BITS-1:0] last_act;
    logic                 ref_due;
    logic [ROW_BITS-1:0]  ref_ptr;
  } bank_st_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [2:0]           command;
    logic [ROW_BITS-1:0]  row;
    logic [TIME_BITS-1:0] now;
    logic [LA_BITS-1:0]   lookahead;
  } item_t;

  typedef struct packed {
    logic                 ok;
    logic [2:0]           bank_mode;
    logic [ROW_BITS-1:0]  current_row;
    logic                 row_conflict;
    logic                 bank_idle;
    logic                 refresh_pending;
    logic [TIME_BITS-1:0] earliest_cycle;
  } res_t;

  function automatic bank_st_t st_reset();
    bank_st_t s;
    s          = '0;
    s.mode     = MODE_CLOSED;
    s.e_ref    = {{(TIME_BITS-32){1'b0}}, REF_SPACING_RST};
    return s;
  endfunction

  function automatic logic is_pd(input logic [2:0] m);
    return (m == MODE_PDA) || (m == MODE_PDF) || (m == MODE_PDS);
  endfunction

  function automatic logic [SUM_BITS-1:0] b12(input logic [7:0] b);
    return {{(SUM_BITS-8){1'b0}}, b};
  endfunction

  function automatic logic [SUM_BITS-1:0] smax(input logic [SUM_BITS-1:0] a,
                                               input logic [SUM_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // negative sums count as zero
  function automatic logic [OFF_BITS-1:0] clampz(input logic [SUM_BITS-1:0] v);
    return v[SUM_BITS-1] ? '0 : {{(OFF_BITS-SUM_BITS){1'b0}}, v};
  endfunction

  // saturating time add
  function automatic logic [TIME_BITS-1:0] tadd(input logic [TIME_BITS-1:0] base,
                                                input logic [OFF_BITS-1:0] off);
    logic [TIME_BITS:0] s;
    s = {1'b0, base} + {{(TIME_BITS+1-OFF_BITS){1'b0}}, off};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] raise(input logic [TIME_BITS-1:0] cur,
                                                 input logic [TIME_BITS-1:0] v);
    return (v > cur) ? v : cur;
  endfunction

endpackage

/* rtl/dbtt_if.sv */
// dbtt_if: valid/ready channel interfaces for the input words and the result words.
// Depends on dbtt_pkg for field widths.
`timescale 1ns / 1ps

interface dbtt_in_if import dbtt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [2:0]           command;
  logic [ROW_BITS-1:0]  row;
  logic [TIME_BITS-1:0] now;
  logic [LA_BITS-1:0]   lookahead;

  modport source(output valid, action, command, row, now, lookahead, input ready);
  modport sink(input valid, action, command, row, now, lookahead, output ready);
endinterface

interface dbtt_out_if import dbtt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [2:0]           bank_mode;
  logic [ROW_BITS-1:0]  current_row;
  logic                 row_conflict;
  logic                 bank_idle;
  logic                 refresh_pending;
  logic [TIME_BITS-1:0] earliest_cycle;

  modport source(output valid, ok, bank_mode, current_row, row_conflict, bank_idle,
                 refresh_pending, earliest_cycle, input ready);
  modport sink(input valid, ok, bank_mode, current_row, row_conflict, bank_idle,
               refresh_pending, earliest_cycle, output ready);
endinterface

/* rtl/dbtt_cfg.sv */
// dbtt_cfg: configuration register file plus the registered refresh busy product.
// Depends on dbtt_pkg.
`timescale 1ns / 1ps

module dbtt_cfg import dbtt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  logic [39:0]          act_timing_r;
  logic [55:0]          col_timing_r;
  logic [23:0]          pd_timing_r;
  logic [15:0]          ref_op_time_r;
  logic [31:0]          ref_spacing_r;
  logic [16:0]          ref_rows_r;
  logic                 ref_en_r;
  logic [BUSY_BITS-1:0] ref_busy_r;
  logic [BUSY_BITS-1:0] ref_busy_nxt;
  logic [15:0]          ref_op_time_nxt;
  logic [16:0]          ref_rows_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_timing_r  <= '0;
      col_timing_r  <= '0;
      pd_timing_r   <= '0;
      ref_op_time_r <= '0;
      ref_spacing_r <= REF_SPACING_RST;
      ref_rows_r    <= REF_ROWS_RST;
      ref_en_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACT_TIMING:  act_timing_r  <= cfg_data[39:0];
        CFG_COL_TIMING:  col_timing_r  <= cfg_data[55:0];
        CFG_PD_TIMING:   pd_timing_r   <= cfg_data[23:0];
        CFG_REF_OP_TIME: ref_op_time_r <= cfg_data[15:0];
        CFG_REF_SPACING: ref_spacing_r <= cfg_data[31:0];
        CFG_REF_ROWS:    ref_rows_r    <= cfg_data[16:0];
        CFG_REF_ENABLE:  ref_en_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // product follows the register writes at the same edge
  assign ref_op_time_nxt = (cfg_we && (cfg_index == CFG_REF_OP_TIME)) ? cfg_data[15:0] :
                           ref_op_time_r;
  assign ref_rows_nxt    = (cfg_we && (cfg_index == CFG_REF_ROWS)) ? cfg_data[16:0] :
                           ref_rows_r;

  // rows per op times op time: 17x16 product, registered
  assign ref_busy_nxt = BUSY_BITS'({16'b0, ref_rows_nxt} * {17'b0, ref_op_time_nxt});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_busy_r <= '0;
    end else begin
      ref_busy_r <= ref_busy_nxt;
    end
  end

  always_comb begin
    cfg.act_timing  = act_timing_r;
    cfg.col_timing  = col_timing_r;
    cfg.pd_timing   = pd_timing_r;
    cfg.ref_op_time = ref_op_time_r;
    cfg.ref_spacing = ref_spacing_r;
    cfg.ref_rows    = ref_rows_r;
    cfg.ref_en      = ref_en_r;
    cfg.ref_busy    = ref_busy_r;
  end

endmodule

/* rtl/dbtt_core.sv */
// dbtt_core: next bank state and result word for one input word, combinational.
// Depends on dbtt_pkg.
`timescale 1ns / 1ps

module dbtt_core import dbtt_pkg::*; (
  input  item_t    item,
  input  bank_st_t st,
  input  cfg_t     cfg,
  output bank_st_t st_nxt,
  output res_t     res
);

  logic [SUM_BITS-1:0]  rcd, ras, rp, al, rrd;
  logic [SUM_BITS-1:0]  bl, ccd, cas, cwd, rtp, wr, wtr;
  logic [SUM_BITS-1:0]  pd, xp, xpdll;
  logic [SUM_BITS-1:0]  rcdras, blccd, xsel;
  logic [TIME_BITS-1:0] now, t_q;
  logic                 blk;
  logic                 ok;
  logic [2:0]           target;
  bank_st_t             n;

  always_comb begin
    rcd    = b12(cfg.act_timing[7:0]);
    ras    = b12(cfg.act_timing[15:8]);
    rp     = b12(cfg.act_timing[23:16]);
    al     = b12(cfg.act_timing[31:24]);
    rrd    = b12(cfg.act_timing[39:32]);
    bl     = b12(cfg.col_timing[7:0]);
    ccd    = b12(cfg.col_timing[15:8]);
    cas    = b12(cfg.col_timing[23:16]);
    cwd    = b12(cfg.col_timing[31:24]);
    rtp    = b12(cfg.col_timing[39:32]);
    wr     = b12(cfg.col_timing[47:40]);
    wtr    = b12(cfg.col_timing[55:48]);
    pd     = b12(cfg.pd_timing[7:0]);
    xp     = b12(cfg.pd_timing[15:8]);
    xpdll  = b12(cfg.pd_timing[23:16]);
    rcdras = smax(rcd, ras);
    blccd  = smax(bl, ccd);
    now    = item.now;
    t_q    = tadd(now, {{(OFF_BITS-LA_BITS){1'b0}}, item.lookahead});
    blk    = cfg.ref_en && st.ref_due;
    ok     = 1'b0;
    target = MODE_PDS;
    xsel   = xp;
    n      = st;

    case (item.action)
      ACTN_QUERY: begin
        case (item.command)
          CMD_ACT: ok = (st.e_act <= t_q) && (st.mode == MODE_CLOSED) &&
                        !(cfg.ref_en && ((t_q >= st.e_ref) || st.ref_due));
          CMD_RD:  ok = (st.e_rd <= t_q) && (st.mode == MODE_OPEN) &&
                        (item.row == st.open_row) && !blk;
          CMD_WR:  ok = (st.e_wr <= t_q) && (st.mode == MODE_OPEN) &&
                        (item.row == st.open_row) && !blk;
          CMD_PRE: ok = (st.e_pre <= t_q) && (st.mode == MODE_OPEN);
          CMD_PU:  ok = (st.e_pu <= t_q) && is_pd(st.mode) && !blk;
          default: ok = (st.e_pd <= t_q) && !is_pd(st.mode) && !blk;
        endcase
      end
      ACTN_ISSUE: begin
        case (item.command)
          CMD_ACT: begin
            if ((st.e_act <= now) && (st.mode == MODE_CLOSED)) begin
              ok         = 1'b1;
              n.e_act    = raise(st.e_act, tadd(now, clampz(rcdras + rp)));
              n.e_pre    = raise(st.e_pre, tadd(now, clampz(rcdras)));
              n.e_rd     = raise(st.e_rd, tadd(now, clampz(rcd - al)));
              n.e_wr     = raise(st.e_wr, tadd(now, clampz(rcd - al)));
              n.e_pd     = raise(st.e_pd, tadd(now, clampz(rcd + 12'd1)));
              n.open_row = item.row;
              n.mode     = MODE_OPEN;
              n.last_act = now;
            end
          end
          CMD_RD: begin
            if ((st.e_rd <= now) && (st.mode == MODE_OPEN) && (item.row == st.open_row)) begin
              ok      = 1'b1;
              n.e_pre = raise(st.e_pre, tadd(now, clampz(al + bl + rtp - ccd)));
              n.e_rd  = raise(st.e_rd, tadd(now, clampz(blccd)));
              n.e_wr  = raise(st.e_wr, tadd(now, clampz(cas + bl + 12'd2 - cwd)));
              n.e_act = raise(st.e_act, tadd(st.last_act, clampz(rrd)));
              n.e_pd  = raise(st.e_pd, tadd(now, clampz(al + bl + cas + 12'd1)));
            end
          end
          CMD_WR: begin
            if ((st.e_wr <= now) && (st.mode == MODE_OPEN) && (item.row == st.open_row)) begin
              ok      = 1'b1;
              n.e_pre = raise(st.e_pre, tadd(now, clampz(al + cwd + bl + wr)));
              n.e_rd  = raise(st.e_rd, tadd(now, clampz(cwd + bl + wtr)));
              n.e_wr  = raise(st.e_wr, tadd(now, clampz(blccd)));
              n.e_pd  = raise(st.e_pd, tadd(now, clampz(al + bl + wr + cwd + 12'd1)));
            end
          end
          CMD_PRE: begin
            if ((st.e_pre <= now) && (st.mode == MODE_OPEN)) begin
              ok      = 1'b1;
              n.e_act = raise(st.e_act, tadd(now, clampz(rp)));
              n.e_pd  = raise(st.e_pd, tadd(now, clampz(rp)));
              n.mode  = MODE_CLOSED;
            end
          end
          CMD_PU: begin
            if ((st.e_pu <= now) && is_pd(st.mode)) begin
              ok      = 1'b1;
              xsel    = (st.mode == MODE_PDS) ? xpdll : xp;
              n.e_pd  = raise(st.e_pd, tadd(now, clampz(xp)));
              n.e_act = raise(st.e_act, tadd(now, clampz(xp)));
              n.e_rd  = raise(st.e_rd, tadd(now, clampz(xsel)));
              n.e_wr  = raise(st.e_wr, tadd(now, clampz(xp)));
              n.e_pre = raise(st.e_pre, tadd(now, clampz(xp)));
              n.mode  = (st.mode == MODE_PDA) ? MODE_OPEN : MODE_CLOSED;
            end
          end
          default: begin
            target = (item.command == CMD_PDA) ? MODE_PDA :
                     (item.command == CMD_PDF) ? MODE_PDF : MODE_PDS;
            xsel   = (target == MODE_PDS) ? xpdll : xp;
            if ((st.e_pd <= now) && !is_pd(st.mode)) begin
              ok      = 1'b1;
              n.mode  = target;
              n.e_pu  = raise(st.e_pu, tadd(now, clampz(pd)));
              n.e_act = raise(st.e_act, tadd(now, clampz(pd + xp)));
              n.e_rd  = raise(st.e_rd, tadd(now, clampz(pd + xsel)));
              n.e_wr  = raise(st.e_wr, tadd(now, clampz(pd + xp)));
              n.e_pre = raise(st.e_pre, tadd(now, clampz(pd + xp)));
            end
          end
        endcase
      end
      ACTN_TICK: begin
        if (cfg.ref_en && (st.e_ref <= now)) begin
          if (st.mode != MODE_CLOSED) begin
            n.ref_due = 1'b1;
          end else begin
            ok        = 1'b1;
            n.e_act   = raise(st.e_act, tadd(now, {1'b0, cfg.ref_busy}));
            n.e_pd    = raise(st.e_pd, tadd(now, {1'b0, cfg.ref_busy}));
            n.ref_ptr = st.ref_ptr + cfg.ref_rows[ROW_BITS-1:0];
            n.e_ref   = tadd(now, {2'b0, cfg.ref_spacing});
            n.ref_due = 1'b0;
          end
        end
      end
      default: ;
    endcase

    st_nxt              = n;
    res.ok              = ok;
    res.bank_mode       = n.mode;
    res.current_row     = n.open_row;
    res.row_conflict    = !((n.mode == MODE_OPEN) && (item.row == n.open_row));
    res.bank_idle       = (n.e_pre <= now) && (n.e_act <= now) && (n.e_rd <= now) &&
                          (n.e_wr <= now) && !is_pd(n.mode);
    res.refresh_pending = n.ref_due;
    case (item.command)
      CMD_ACT: res.earliest_cycle = n.e_act;
      CMD_RD:  res.earliest_cycle = n.e_rd;
      CMD_WR:  res.earliest_cycle = n.e_wr;
      CMD_PRE: res.earliest_cycle = n.e_pre;
      CMD_PU:  res.earliest_cycle = n.e_pu;
      default: res.earliest_cycle = n.e_pd;
    endcase
  end

endmodule

/* rtl/dram_bank_timing_tracker_unit.sv */
// Top level of the DRAM bank timing tracker: input register, bank state, result register.
// Depends on dbtt_pkg, dbtt_if, dbtt_cfg and dbtt_core.
`timescale 1ns / 1ps

// Usage:
//   in_ch  : valid/ready words {action, command, row, now, lookahead}. A word is
//            taken at a clock edge with valid and ready high.
//   out_ch : one result word per input word, in order, valid/ready.
//   cfg_*  : write-only register port; write only while no word is in flight.
// Order: a word in the input register is evaluated against the bank state; its result
//   is registered and shown when the word advances. The bank state is updated at
//   that same edge unless cfg_we is high then, so the next word sees it.
// Throughput: one word per cycle while out_ch is not stalled; the single state update per cycle sets it.
// Stall: while the result register holds an untaken word, the input register
//   keeps its word and in_ch.ready drops once that register is full too.
// Reset (rst_n low, synchronous): both registers empty, bank closed, all
//   bounds zero except the refresh bound at 7800, default configuration.
// Writing the refresh spacing also reloads the refresh bound; writing
//   start_powered_down as 1 puts a closed bank into fast power-down.

module dram_bank_timing_tracker_unit import dbtt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  dbtt_in_if.sink                  in_ch,
  dbtt_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t     cfg;
  item_t    item_r;
  logic     in_valid_r;
  logic     out_valid_r;
  res_t     res_r;
  res_t     res_nxt;
  bank_st_t st_r;
  bank_st_t st_nxt;
  logic     advance;
  logic     in_take;

  dbtt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dbtt_core u_core (
    .item   (item_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action    <= in_ch.action;
      item_r.command   <= in_ch.command;
      item_r.row       <= in_ch.row;
      item_r.now       <= in_ch.now;
      item_r.lookahead <= in_ch.lookahead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_reset();
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_SPACING: st_r.e_ref <= {{(TIME_BITS-32){1'b0}}, cfg_data[31:0]};
        CFG_START_PD: begin
          if (cfg_data[0] && (st_r.mode == MODE_CLOSED)) begin
            st_r.mode <= MODE_PDF;
          end
        end
        default: ;
      endcase
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.ok              = res_r.ok;
  assign out_ch.bank_mode       = res_r.bank_mode;
  assign out_ch.current_row     = res_r.current_row;
  assign out_ch.row_conflict    = res_r.row_conflict;
  assign out_ch.bank_idle       = res_r.bank_idle;
  assign out_ch.refresh_pending = res_r.refresh_pending;
  assign out_ch.earliest_cycle  = res_r.earliest_cycle;

endmodule

/* rtl/dbtt_checker.sv */
// dbtt_checker: port-level assertions for the DRAM bank timing tracker, bound to the top.
// Depends on dbtt_pkg and dbtt_if.
`timescale 1ns / 1ps

module dbtt_checker import dbtt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  dbtt_out_if.source out_ch
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result word valid right after reset");

  a_pd_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.bank_mode == MODE_PDA || out_ch.bank_mode == MODE_PDF ||
                     out_ch.bank_mode == MODE_PDS) |-> !out_ch.bank_idle)
    else $error("powered-down bank reported idle");

  a_hit_means_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.row_conflict |-> out_ch.bank_mode == MODE_OPEN)
    else $error("row hit reported on a bank that is not open");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result word dropped while stalled");

  a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.earliest_cycle) &&
                                      $stable(out_ch.ok))
    else $error("stalled result word changed");

endmodule

bind dram_bank_timing_tracker_unit dbtt_checker u_dbtt_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);
